// ----- rtl/modular_exponentiation_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Clocked on clk_i; MODEXP_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MODEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MODEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define MODEXP_ASSERT(lbl, prop, msg)

`define MODEXP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths, constants and unit interface types of the modular exponentiation.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int MOD_BITS = 31;
  localparam int EXP_BITS = 63;
  localparam int PROD_W   = 2 * MOD_BITS;
  // two remainder bits retired per cycle
  localparam int RED_STEPS = PROD_W / 2;
  localparam int CNT_W     = $clog2(RED_STEPS + 1);

  localparam int IN_TDATA_W  = ((MOD_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MOD_BITS + 7) / 8) * 8;

  localparam logic [MOD_BITS-1:0] MOD_RESET = {MOD_BITS{1'b1}};

  localparam logic REQ_POWER   = 1'b0;
  localparam logic REQ_INVERSE = 1'b1;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] res;
  } mm_rsp_t;

endpackage

// ----- rtl/modexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// modexp_mulmod
// Shared modular multiplier: registered product, then a serial restoring
// remainder that retires two product bits per cycle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modexp_mulmod import modexp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MOD_BITS-1:0] mod_i,
  input  mm_req_t             req_i,
  output mm_rsp_t             rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [MOD_BITS-1:0] rem_q, rem_d;

  logic [MOD_BITS:0] mod_ext;
  logic [MOD_BITS:0] r1, r2;

  assign mod_ext = {1'b0, mod_i};

  always_comb begin
    r1 = {rem_q, prod_q[PROD_W-1]};
    if (r1 >= mod_ext) begin
      r1 = r1 - mod_ext;
    end
    r2 = {r1[MOD_BITS-1:0], prod_q[PROD_W-2]};
    if (r2 >= mod_ext) begin
      r2 = r2 - mod_ext;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      prod_d = PROD_W'(req_i.a) * PROD_W'(req_i.b);
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[PROD_W-3:0], 2'b00};
      rem_d  = r2[MOD_BITS-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RED_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = rem_q;

  `MODEXP_ASSERT(a_no_start_when_busy, req_i.start |-> !busy_q, "start while busy")
  `MODEXP_ASSERT(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q, "stray done")
  `MODEXP_ASSERT(a_rem_reduced, done_q && (mod_i > MOD_BITS'(1)) |-> rem_q < mod_i,
                 "remainder not reduced")
  `MODEXP_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !busy_q && !done_q, "busy in reset")

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Items are taken one at a time: s_axis_tready is low while an item is in work, and a
// finished item waits in S_OUT while the previous result still waits on m_axis_tready.
// A modulus below 2 (result 0) or a zero effective exponent (result 1) skips mulmod.
// Reset (rst_ni, async low) returns to idle and sets the modulus to 2^31 - 1.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square and multiply sequencer around the shared mulmod unit.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MOD_BITS-1:0]    cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [30:0] base, [93:31] exponent, [95:94] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [30:0] result, [31] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RED   = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_MACC  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_MSQ   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [MOD_BITS-1:0] mod_q;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] sq_q, sq_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0] out_q, out_d;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [MOD_BITS-1:0] in_base;
  logic [EXP_BITS-1:0] in_exp, eff_exp;
  logic                in_fire;

  assign in_base = s_axis_tdata[MOD_BITS-1:0];
  assign in_exp  = s_axis_tdata[MOD_BITS+EXP_BITS-1:MOD_BITS];
  assign eff_exp = (s_axis_tuser == REQ_INVERSE) ? EXP_BITS'(mod_q - MOD_BITS'(2)) : in_exp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mm_req      = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          exp_d = eff_exp;
          if (mod_q < MOD_BITS'(2)) begin
            acc_d   = '0;
            state_d = S_OUT;
          end else if (eff_exp == '0) begin
            acc_d   = MOD_BITS'(1);
            state_d = S_OUT;
          end else begin
            // reduce the base: base * 1 mod m
            mm_req.start = 1'b1;
            mm_req.a     = in_base;
            mm_req.b     = MOD_BITS'(1);
            state_d      = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_rsp.done) begin
          sq_d    = mm_rsp.res;
          acc_d   = MOD_BITS'(1);
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (exp_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = acc_q;
          mm_req.b     = sq_q;
          state_d      = S_MACC;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_MACC: begin
        if (mm_rsp.done) begin
          acc_d   = mm_rsp.res;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        exp_d = exp_q >> 1;
        if (|exp_q[EXP_BITS-1:1]) begin
          mm_req.start = 1'b1;
          mm_req.a     = sq_q;
          mm_req.b     = sq_q;
          state_d      = S_MSQ;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MSQ: begin
        if (mm_rsp.done) begin
          sq_d    = mm_rsp.res;
          state_d = S_STEP;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MOD_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    out_q <= out_d;
  end

  modexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

// ----- bench/modexp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modexp_checker
// Watches the config port and both stream channels, computes the expected
// power for every accepted request and compares it with the returned result.
// ----------------------------------------------------------------------------
module modexp_checker import modexp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MOD_BITS-1:0]    cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [30:0] base, [93:31] exponent, [95:94] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [30:0] result, [31] zero
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);

  localparam int EXP_DEPTH = 16;

  logic [MOD_BITS-1:0] modulus_q;
  // ring of predicted results, oldest at rd_idx
  logic [MOD_BITS-1:0] expected_powers[EXP_DEPTH];
  logic [3:0]          wr_idx;
  logic [3:0]          rd_idx;

  // Right-to-left square and multiply; products stay below 2^62.
  function automatic logic [MOD_BITS-1:0] power_mod(input logic req,
                                                    input logic [MOD_BITS-1:0] b,
                                                    input logic [EXP_BITS-1:0] e,
                                                    input logic [MOD_BITS-1:0] m);
    logic [63:0]         acc;
    logic [63:0]         sq;
    logic [63:0]         m64;
    logic [EXP_BITS-1:0] ee;
    if (m < MOD_BITS'(2)) return '0;
    ee = e;
    if (req == REQ_INVERSE) ee = EXP_BITS'(m) - EXP_BITS'(2);
    if (ee == '0) return MOD_BITS'(1);
    m64 = 64'(m);
    acc = 64'(1) % m64;
    sq  = 64'(b) % m64;
    while (ee != '0) begin
      if (ee[0]) acc = (acc * sq) % m64;
      ee = ee >> 1;
      if (ee != '0) sq = (sq * sq) % m64;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] got,
                                 input logic [OUT_TDATA_W-1:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [MOD_BITS-1:0] want;
    if (!rst_ni) begin
      modulus_q = MOD_RESET;
      wr_idx = '0;
      rd_idx = '0;
      pending_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (pending_count == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, '0);
        end else begin
          want = expected_powers[rd_idx];
          rd_idx++;
          pending_count--;
          if (m_axis_tdata[MOD_BITS-1:0] !== want)
            report_mismatch("result", m_axis_tdata, OUT_TDATA_W'(want));
          if (m_axis_tdata[OUT_TDATA_W-1:MOD_BITS] !== '0)
            report_mismatch("tdata padding", m_axis_tdata, OUT_TDATA_W'(want));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_powers[wr_idx] = power_mod(s_axis_tuser, s_axis_tdata[MOD_BITS-1:0],
                                            s_axis_tdata[MOD_BITS +: EXP_BITS], modulus_q);
        wr_idx++;
        pending_count++;
      end
      // the block takes a new modulus after this edge
      if (cfg_we_i) modulus_q = cfg_wdata_i;
    end
  end

endmodule

// ----- bench/tb_modular_exponentiation.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Drives power and inverse requests through several modulus settings, with
// bursty input and a stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation import modexp_pkg::*; ();

  localparam int QUIET_LIMIT   = 40000;
  // longer than two worst-case items, so the block fills and stalls its input
  localparam int HOLD_CYCLES   = 9000;
  localparam int DRAIN_CYCLES  = 4300;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 17;

  localparam logic [MOD_BITS-1:0] MOD_MAX  = {MOD_BITS{1'b1}};
  localparam logic [EXP_BITS-1:0] EXP_ONES = {EXP_BITS{1'b1}};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [MOD_BITS-1:0]    cfg_wdata_i;
  logic                   s_axis_tvalid;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending_count;
  int result_count;

  int                  burst_left;
  int                  sent_count;
  int                  inverse_count;
  int                  setting_count;
  int                  quiet_cycles;
  bit                  hold_req;
  logic [MOD_BITS-1:0] modulus_now;

  modular_exponentiation u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  modexp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Output side: random stall modes, plus one long hold-off on request.
  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_seen;
    m_axis_tready = 1'b0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    hold_seen = 1'b0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
      end
      hold_seen = hold_req;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     m_axis_tready <= 1'b1;
          RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_axis_tready <= ((tick % 7) > 2);
          default:     m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_count);
      $display("[modular_exponentiation] ERROR");
      $finish;
    end
  end

  // Sends one request; starts a new burst after a random gap when due.
  task automatic send_req(input logic req, input logic [MOD_BITS-1:0] b,
                          input logic [EXP_BITS-1:0] e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({e, b});
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (req == REQ_INVERSE) inverse_count++;
  endtask

  // Waits until the block is idle with nothing outstanding, then writes.
  task automatic set_modulus(input logic [MOD_BITS-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0 || !s_axis_tready) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_now = value;
    setting_count++;
  endtask

  initial begin : stimulus
    logic                req;
    logic [MOD_BITS-1:0] b;
    logic [EXP_BITS-1:0] e;
    logic [MOD_BITS-1:0] m;
    int                  sel;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_POWER;
    hold_req      = 1'b0;
    burst_left    = 0;
    modulus_now   = MOD_RESET;
    setting_count = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus 2^31 - 1
    send_req(REQ_POWER, '0, '0);
    send_req(REQ_POWER, '0, EXP_BITS'(5));
    send_req(REQ_POWER, MOD_MAX, EXP_BITS'(1));
    send_req(REQ_POWER, MOD_MAX - MOD_BITS'(1), EXP_ONES);
    send_req(REQ_POWER, MOD_BITS'(2), EXP_BITS'(30));
    send_req(REQ_POWER, MOD_BITS'(3), EXP_ONES);
    send_req(REQ_POWER, MOD_BITS'(1), EXP_BITS'(1) << (EXP_BITS - 1));
    send_req(REQ_POWER, MOD_MAX, '0);
    send_req(REQ_INVERSE, '0, EXP_BITS'(9));
    send_req(REQ_INVERSE, MOD_BITS'(2), '0);
    send_req(REQ_INVERSE, MOD_MAX - MOD_BITS'(1), EXP_ONES);
    send_req(REQ_POWER, MOD_BITS'({(MOD_BITS + 1) / 2{2'b01}}),
             EXP_BITS'({(EXP_BITS + 1) / 2{2'b10}}));
    // inverse with modulus two uses exponent zero
    set_modulus(MOD_BITS'(2));
    send_req(REQ_INVERSE, '0, EXP_BITS'(3));
    send_req(REQ_INVERSE, MOD_BITS'(5), '0);
    send_req(REQ_POWER, MOD_BITS'(3), EXP_BITS'(7));
    send_req(REQ_POWER, MOD_BITS'(4), EXP_BITS'(3));
    // degenerate moduli always answer zero
    set_modulus('0);
    send_req(REQ_POWER, MOD_BITS'(5), EXP_BITS'(3));
    send_req(REQ_INVERSE, MOD_BITS'(5), EXP_BITS'(3));
    send_req(REQ_POWER, MOD_BITS'(5), '0);
    set_modulus(MOD_BITS'(1));
    send_req(REQ_POWER, '0, '0);
    send_req(REQ_INVERSE, MOD_BITS'(7), EXP_ONES);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       m = MOD_MAX;
        1:       m = MOD_BITS'($urandom) | (MOD_BITS'(1) << (MOD_BITS - 1));
        2:       m = MOD_BITS'($urandom_range(2, 64));
        3:       m = MOD_BITS'(2147483629);
        4:       m = MOD_BITS'(32'h0001_0000);
        5:       m = MOD_BITS'($urandom);
        default: m = MOD_BITS'(3);
      endcase
      set_modulus(m);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 5) begin
          // long output stall while requests keep coming back to back
          hold_req = 1'b1;
          burst_left = 4;
        end
        req = ($urandom_range(0, 3) == 0) ? REQ_INVERSE : REQ_POWER;
        sel = $urandom_range(0, 9);
        case (sel)
          0:       b = '0;
          1:       b = MOD_MAX;
          2:       b = modulus_now - MOD_BITS'(1);
          3:       b = MOD_BITS'(1);
          default: b = MOD_BITS'($urandom);
        endcase
        sel = $urandom_range(0, 9);
        e = EXP_BITS'({$urandom, $urandom});
        case (sel)
          0:       e = EXP_ONES;
          1:       e = EXP_BITS'(1) << $urandom_range(0, EXP_BITS - 1);
          2, 3:    ;
          default: e = e & ((EXP_BITS'(1) << $urandom_range(0, 40)) - EXP_BITS'(1));
        endcase
        send_req(req, b, e);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d inverse) over %0d modulus settings",
             sent_count, inverse_count, setting_count);
    $display("checked %0d results, %0d mismatches", result_count, fail_count);
    if (fail_count == 0)
      $display("[modular_exponentiation] OK");
    else
      $display("[modular_exponentiation] ERROR");
    $finish;
  end

endmodule
